FILE: sv/bvoe_pkg.sv
package bvoe_pkg;

  // Field widths of the request and response transactions
  localparam int VTX_W  = 7;
  localparam int MODE_W = 2;

  // Configuration port
  localparam int APB_DW  = 32;
  localparam int PADDR_W = 3;

  // Register map (word index taken from paddr[PADDR_W-1:2])
  localparam logic [PADDR_W-3:0] REG_VERTEX_COUNT = '0;

  localparam logic [VTX_W-1:0] VERTEX_COUNT_RST = 7'd64;

  // Request opcodes
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_EDGE = 2'd0,
    MODE_CLEAR    = 2'd1,
    MODE_TRAVERSE = 2'd2
  } mode_e;

endpackage

FILE: sv/bvoe_if.sv
// Request channel: one graph command per transaction
interface bvoe_req_if import bvoe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [VTX_W-1:0]  vertex_a;
  logic [VTX_W-1:0]  vertex_b;

  modport source (output valid, mode, vertex_a, vertex_b, input ready);
  modport sink   (input valid, mode, vertex_a, vertex_b, output ready);
endinterface

// Response channel: one visited vertex per transaction
interface bvoe_rsp_if import bvoe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] visited_vertex;
  logic             last;
  logic             bad_start;

  modport source (output valid, visited_vertex, last, bad_start, input ready);
  modport sink   (input valid, visited_vertex, last, bad_start, output ready);
endinterface

FILE: sv/bvoe_adj.sv
// Adjacency matrix: one row per vertex in a RAM with one read and one write port, registered read.
// Per-row valid flags give an instant clear; an invalid row reads as zero.
module bvoe_adj #(
  parameter int MAX_VERTICES = 64,
  localparam int IDX_W = $clog2(MAX_VERTICES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clr_i,
  input  logic                    rd_en_i,
  input  logic [IDX_W-1:0]        rd_idx_i,
  output logic [MAX_VERTICES-1:0] rd_row_o,
  input  logic                    wr_en_i,
  input  logic [IDX_W-1:0]        wr_idx_i,
  input  logic [MAX_VERTICES-1:0] wr_row_i
);

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rd_data_q;
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic                    rd_vld_q;

  // RAM array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  // Row valid flags; clear wins over a same-cycle write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (clr_i) begin
        row_vld_q <= '0;
      end else if (wr_en_i) begin
        row_vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_idx_i];
      end
    end
  end

  assign rd_row_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: sv/bvoe_queue.sv
// BFS work queue: RAM with head/tail pointers, registered pop data.
// Entries are only read after being written within the same traversal.
module bvoe_queue import bvoe_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  localparam int IDX_W = $clog2(MAX_VERTICES),
  localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             push_i,
  input  logic [VTX_W-1:0] push_data_i,
  input  logic             pop_i,
  output logic [VTX_W-1:0] pop_data_o,
  output logic             empty_o
);

  logic [VTX_W-1:0] mem [MAX_VERTICES];
  logic [VTX_W-1:0] pop_data_q;
  logic [CNT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] wr_ptr;

  // A clear with a push restarts the queue holding one entry
  always_comb begin
    wr_ptr = clr_i ? '0 : tail_q;
    head_d = head_q;
    tail_d = tail_q;
    if (clr_i) begin
      head_d = '0;
      tail_d = push_i ? CNT_W'(1) : '0;
    end else begin
      if (push_i) tail_d = tail_q + CNT_W'(1);
      if (pop_i)  head_d = head_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr[IDX_W-1:0]] <= push_data_i;
    end
    if (pop_i) begin
      pop_data_q <= mem[head_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  assign pop_data_o = pop_data_q;
  assign empty_o    = (head_q == tail_q);

endmodule

FILE: sv/bfs_visit_order_engine.sv
// Add edge: two row read-modify-writes, A then B. Clear: a flag clear in
// idle. Traversal per dequeued vertex: queue pop, matrix row read, mask,
// then a scan that emits one newly found vertex per cycle while the output
// is free and returns to the pop when none is left; a bad start goes to
// the final result. One request at a time. Reset is async active low: matrix
// cleared at once via row valid flags, vertex_count = 64, no clearing pass.
module bfs_visit_order_engine import bvoe_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bvoe_req_if.sink            req_i,
  bvoe_rsp_if.source          rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam logic [VTX_W-1:0] MAX_N = VTX_W'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] ROW_ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_WRA,
    ST_EDGE_RDB,
    ST_EDGE_WRB,
    ST_POP,
    ST_ROW,
    ST_LOAD,
    ST_SCAN,
    ST_FINAL
  } state_e;

  state_e state_q, state_d;

  logic [VTX_W-1:0]        vc_q;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [MAX_VERTICES-1:0] fresh_q, fresh_d;
  logic [VTX_W-1:0]        held_vtx_q, held_vtx_d;
  logic                    held_bad_q, held_bad_d;
  logic [IDX_W-1:0]        a_idx_q, a_idx_d;
  logic [IDX_W-1:0]        b_idx_q, b_idx_d;
  logic                    out_valid_q, out_valid_d;
  logic [VTX_W-1:0]        out_vtx_q, out_vtx_d;
  logic                    out_last_q, out_last_d;
  logic                    out_bad_q, out_bad_d;

  logic [VTX_W-1:0]        n_live;
  logic [MAX_VERTICES-1:0] live_mask;
  logic                    a_ok, b_ok;
  logic [VTX_W-1:0]        a_m1, b_m1, x_m1;
  logic                    out_free;
  logic                    cfg_wr;

  logic [MAX_VERTICES-1:0] pick_onehot;
  logic [IDX_W-1:0]        pick_idx;
  logic [VTX_W-1:0]        pick_vtx;

  logic                    adj_clr, adj_rd_en, adj_wr_en;
  logic [IDX_W-1:0]        adj_rd_idx, adj_wr_idx;
  logic [MAX_VERTICES-1:0] adj_rd_row, adj_wr_row;

  logic                    q_clr, q_push, q_pop, q_empty;
  logic [VTX_W-1:0]        q_push_data, q_pop_data;

  bvoe_adj #(.MAX_VERTICES(MAX_VERTICES)) u_adj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (adj_clr),
    .rd_en_i  (adj_rd_en),
    .rd_idx_i (adj_rd_idx),
    .rd_row_o (adj_rd_row),
    .wr_en_i  (adj_wr_en),
    .wr_idx_i (adj_wr_idx),
    .wr_row_i (adj_wr_row)
  );

  bvoe_queue #(.MAX_VERTICES(MAX_VERTICES)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (q_clr),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  // Configuration register
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT);
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT) ? APB_DW'(vc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VERTEX_COUNT_RST;
    end else if (cfg_wr) begin
      vc_q <= pwdata[VTX_W-1:0];
    end
  end

  // Live vertex range and endpoint checks
  assign n_live = (vc_q > MAX_N) ? MAX_N : vc_q;
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live_mask[i] = (VTX_W'(i) < n_live);
    end
  end
  assign a_ok = (req_i.vertex_a != '0) && (req_i.vertex_a <= n_live);
  assign b_ok = (req_i.vertex_b != '0) && (req_i.vertex_b <= n_live);
  assign a_m1 = req_i.vertex_a - VTX_W'(1);
  assign b_m1 = req_i.vertex_b - VTX_W'(1);
  assign x_m1 = q_pop_data - VTX_W'(1);

  // Lowest unvisited neighbor of the current row
  always_comb begin
    pick_onehot = fresh_q & (~fresh_q + ROW_ONE);
    pick_idx    = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (pick_onehot[i]) pick_idx = pick_idx | IDX_W'(i);
    end
    pick_vtx = {{(VTX_W-IDX_W){1'b0}}, pick_idx} + VTX_W'(1);
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;

  // Sequencer: one result is held back so the final one can carry last
  always_comb begin
    state_d     = state_q;
    visited_d   = visited_q;
    fresh_d     = fresh_q;
    held_vtx_d  = held_vtx_q;
    held_bad_d  = held_bad_q;
    a_idx_d     = a_idx_q;
    b_idx_d     = b_idx_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_vtx_d   = out_vtx_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;
    adj_clr     = 1'b0;
    adj_rd_en   = 1'b0;
    adj_rd_idx  = a_m1[IDX_W-1:0];
    adj_wr_en   = 1'b0;
    adj_wr_idx  = a_idx_q;
    adj_wr_row  = adj_rd_row | (ROW_ONE << b_idx_q);
    q_clr       = 1'b0;
    q_push      = 1'b0;
    q_push_data = pick_vtx;
    q_pop       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          a_idx_d = a_m1[IDX_W-1:0];
          b_idx_d = b_m1[IDX_W-1:0];
          unique case (mode_e'(req_i.mode))
            MODE_ADD_EDGE: begin
              if (a_ok && b_ok) begin
                adj_rd_en = 1'b1;
                state_d   = ST_EDGE_WRA;
              end
            end
            MODE_CLEAR: begin
              adj_clr = 1'b1;
            end
            MODE_TRAVERSE: begin
              if (a_ok) begin
                visited_d   = ROW_ONE << a_m1[IDX_W-1:0];
                q_clr       = 1'b1;
                q_push      = 1'b1;
                q_push_data = req_i.vertex_a;
                held_vtx_d  = req_i.vertex_a;
                held_bad_d  = 1'b0;
                state_d     = ST_POP;
              end else begin
                held_vtx_d = '0;
                held_bad_d = 1'b1;
                state_d    = ST_FINAL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EDGE_WRA: begin
        adj_wr_en = 1'b1;
        state_d   = ST_EDGE_RDB;
      end
      ST_EDGE_RDB: begin
        adj_rd_en  = 1'b1;
        adj_rd_idx = b_idx_q;
        state_d    = ST_EDGE_WRB;
      end
      ST_EDGE_WRB: begin
        adj_wr_en  = 1'b1;
        adj_wr_idx = b_idx_q;
        adj_wr_row = adj_rd_row | (ROW_ONE << a_idx_q);
        state_d    = ST_IDLE;
      end
      ST_POP: begin
        if (q_empty) begin
          state_d = ST_FINAL;
        end else begin
          q_pop   = 1'b1;
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        adj_rd_en  = 1'b1;
        adj_rd_idx = x_m1[IDX_W-1:0];
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        fresh_d = adj_rd_row & live_mask & ~visited_q;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (fresh_q == '0) begin
          state_d = ST_POP;
        end else if (out_free) begin
          q_push      = 1'b1;
          visited_d   = visited_q | pick_onehot;
          fresh_d     = fresh_q & ~pick_onehot;
          out_valid_d = 1'b1;
          out_vtx_d   = held_vtx_q;
          out_last_d  = 1'b0;
          out_bad_d   = held_bad_q;
          held_vtx_d  = pick_vtx;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_vtx_d   = held_vtx_q;
          out_last_d  = 1'b1;
          out_bad_d   = held_bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      visited_q   <= '0;
      fresh_q     <= '0;
      held_vtx_q  <= '0;
      held_bad_q  <= 1'b0;
      a_idx_q     <= '0;
      b_idx_q     <= '0;
      out_valid_q <= 1'b0;
      out_vtx_q   <= '0;
      out_last_q  <= 1'b0;
      out_bad_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      visited_q   <= visited_d;
      fresh_q     <= fresh_d;
      held_vtx_q  <= held_vtx_d;
      held_bad_q  <= held_bad_d;
      a_idx_q     <= a_idx_d;
      b_idx_q     <= b_idx_d;
      out_valid_q <= out_valid_d;
      out_vtx_q   <= out_vtx_d;
      out_last_q  <= out_last_d;
      out_bad_q   <= out_bad_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.visited_vertex = out_vtx_q;
  assign rsp_o.last           = out_last_q;
  assign rsp_o.bad_start      = out_bad_q;

endmodule

FILE: sv/bvoe_checker.sv
// Port-level checks for the BFS engine
module bvoe_checker import bvoe_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [VTX_W-1:0] rsp_vertex,
  input logic             rsp_last,
  input logic             rsp_bad
);

  // No response while in reset
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |-> !rsp_valid)
    else $error("response valid during reset");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex) &&
    $stable(rsp_last) && $stable(rsp_bad))
    else $error("response changed while stalled");

  // Bad start is a lone terminating result with vertex zero
  a_bad_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_bad |-> rsp_last && (rsp_vertex == '0))
    else $error("malformed bad-start response");

  // A good result always names a real vertex
  a_good_vtx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_bad |-> (rsp_vertex != '0))
    else $error("good response with vertex zero");

  // Mid-traversal the engine takes no new request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_last |-> !req_ready)
    else $error("request accepted during traversal");

endmodule

bind bfs_visit_order_engine bvoe_checker u_bvoe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid  (req_i.valid),
  .req_ready  (req_i.ready),
  .rsp_valid  (rsp_o.valid),
  .rsp_ready  (rsp_o.ready),
  .rsp_vertex (rsp_o.visited_vertex),
  .rsp_last   (rsp_o.last),
  .rsp_bad    (rsp_o.bad_start)
);
